// File: rtl/lrpsc_pkg.sv
// package: operation codes, register indexes and ring pattern tables for the led ring scan core
`timescale 1ns / 1ps

package lrpsc_pkg;

    localparam int LRPSC_NUM_RINGS = 8;
    localparam int CFG_INDEX_W     = 8;

    localparam logic [2:0] OP_SET_POSITION = 3'd0;
    localparam logic [2:0] OP_SET_GPC      = 3'd1;
    localparam logic [2:0] OP_SET_METER    = 3'd2;
    localparam logic [2:0] OP_ADD_MASK     = 3'd3;
    localparam logic [2:0] OP_UPDATE       = 3'd4;
    localparam logic [2:0] OP_SCAN         = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_GPC_MODE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP       = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_CATH  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_METER_CATH = CFG_INDEX_W'(3);

    localparam logic [15:0] HUB_LED = 16'h0800;

    localparam logic [15:0] NORMAL_TABLE [64] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020, 16'h0040,
        16'h0080, 16'h0100, 16'h0200, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400,
        16'h0000, 16'h003f, 16'h003e, 16'h003c, 16'h0038, 16'h0030, 16'h0020, 16'h0060,
        16'h00e0, 16'h01e0, 16'h03e0, 16'h07e0, 16'h07e0, 16'h07e0, 16'h07e0, 16'h07e0,
        16'h0000, 16'h0001, 16'h0003, 16'h0007, 16'h000f, 16'h001f, 16'h003f, 16'h007f,
        16'h00ff, 16'h01ff, 16'h03ff, 16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff,
        16'h0000, 16'h0020, 16'h0070, 16'h00f8, 16'h01fc, 16'h03fe, 16'h07ff, 16'h07ff,
        16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff, 16'h07ff
    };

    localparam logic [15:0] GPC_TABLE [32] = '{
        16'h0001, 16'h0001, 16'h0003, 16'h0003, 16'h0003, 16'h0007, 16'h0007, 16'h0007,
        16'h000f, 16'h000f, 16'h000f, 16'h001f, 16'h001f, 16'h001f, 16'h003f, 16'h003f,
        16'h003f, 16'h003f, 16'h007f, 16'h007f, 16'h007f, 16'h00ff, 16'h00ff, 16'h00ff,
        16'h01ff, 16'h01ff, 16'h01ff, 16'h03ff, 16'h03ff, 16'h03ff, 16'h07ff, 16'h07ff
    };

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    function automatic logic [15:0] ring_pattern(input logic gpc, input logic [6:0] v);
        logic [15:0] p;
        if (gpc) begin
            p = GPC_TABLE[v[6:2]];
        end else begin
            p = NORMAL_TABLE[v[5:0]] | (v[6] ? HUB_LED : 16'h0000);
        end
        return p;
    endfunction

endpackage

// File: rtl/led_ring_pattern_scan_controller_core.sv
// top level: led ring and meter multiplex scan controller
//
// input channel (s_valid/s_ready) takes one command word: position, gpc value and meter
// writes and mask adds complete in the accept cycle. an update word walks the rings one
// per cycle through a shared pattern lookup, so it holds s_ready low until the walk has
// passed the last ring. a scan word enters the scan state, which loads the result
// register once it is free; the result (m_valid/m_ready) carries cathode masks and
// the anode pattern. s_ready returns once the result register has taken the scan word,
// so a new command word is taken while the previous result waits. if the receiver stalls,
// a second scan word waits in the scan state until the result register frees up.
// a scan with no cathode group fitted gives no result.
// configuration port (cfg_valid/cfg_ready) is always ready and writes one register per
// word; write only while no command word is in flight.
// reset (aresetn low, synchronous) clears all ring stores and the scan counter, sets every
// update flag and empties the result register.
`timescale 1ns / 1ps

module led_ring_pattern_scan_controller_core
    import lrpsc_pkg::*;
#(
    parameter int NUM_RINGS = LRPSC_NUM_RINGS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_operation,
    input  logic [2:0]             s_ring_index,
    input  logic [6:0]             s_position,
    input  logic [15:0]            s_meter_bits,
    input  logic [7:0]             s_update_mask,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ring_cathode_valid,
    output logic [7:0]             m_ring_cathode_mask,
    output logic                   m_meter_cathode_valid,
    output logic [7:0]             m_meter_cathode_mask,
    output logic [15:0]            m_anode_bits
);

    localparam int IDX_W = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam logic [IDX_W-1:0] LAST_RING = IDX_W'(NUM_RINGS - 1);

    state_t state_reg;

    logic gpc_mode_reg;
    logic swap_reg;
    logic ring_en_reg;
    logic meter_en_reg;

    logic [6:0]           ring_positions_reg [NUM_RINGS];
    logic [6:0]           gpc_values_reg     [NUM_RINGS];
    logic [15:0]          meter_patterns_reg [NUM_RINGS];
    logic [15:0]          ring_patterns_reg  [NUM_RINGS];
    logic [NUM_RINGS-1:0] update_flags_reg;
    logic [3:0]           scan_counter_reg;
    logic [IDX_W-1:0]     walk_reg;

    logic        m_valid_reg;
    logic        rv_reg;
    logic        mv_reg;
    logic [7:0]  rmask_reg;
    logic [7:0]  mmask_reg;
    logic [15:0] anode_reg;

    logic             s_fire;
    logic             idx_ok;
    logic [IDX_W-1:0] widx;
    logic [6:0]       walk_value;
    logic [15:0]      walk_pattern;
    logic             both_groups;
    logic [3:0]       scan_counter_next;
    logic [2:0]       slot;
    logic [7:0]       sel;
    logic             ring_half;
    logic             slot_ok;
    logic [15:0]      ring_slot_pattern;
    logic [15:0]      meter_slot_pattern;
    logic [15:0]      anode_next;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign idx_ok    = (32'(s_ring_index) < NUM_RINGS);
    assign widx      = s_ring_index[IDX_W-1:0];

    // shared pattern lookup for the update walk
    assign walk_value   = gpc_mode_reg ? gpc_values_reg[walk_reg] : ring_positions_reg[walk_reg];
    assign walk_pattern = ring_pattern(gpc_mode_reg, walk_value);

    assign both_groups       = ring_en_reg && meter_en_reg;
    assign scan_counter_next = both_groups ? scan_counter_reg + 4'd1
                                           : {1'b0, scan_counter_reg[2:0] + 3'd1};
    assign slot      = scan_counter_next[2:0];
    assign sel       = ~(8'd1 << slot);
    assign ring_half = both_groups ? !scan_counter_next[3] : ring_en_reg;
    assign slot_ok   = (32'(slot) < NUM_RINGS);

    assign ring_slot_pattern  = slot_ok ? ring_patterns_reg[slot[IDX_W-1:0]] : 16'h0000;
    assign meter_slot_pattern = slot_ok ? meter_patterns_reg[slot[IDX_W-1:0]] : 16'h0000;
    assign anode_next = (ring_half != swap_reg) ? ring_slot_pattern : meter_slot_pattern;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gpc_mode_reg <= 1'b0;
            swap_reg     <= 1'b0;
            ring_en_reg  <= 1'b1;
            meter_en_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GPC_MODE:   gpc_mode_reg <= cfg_data;
                CFG_SWAP:       swap_reg     <= cfg_data;
                CFG_RING_CATH:  ring_en_reg  <= cfg_data;
                CFG_METER_CATH: meter_en_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            update_flags_reg <= '1;
            scan_counter_reg <= 4'd0;
            walk_reg         <= '0;
            for (int i = 0; i < NUM_RINGS; i++) begin
                ring_positions_reg[i] <= 7'd0;
                gpc_values_reg[i]     <= 7'd0;
                meter_patterns_reg[i] <= 16'h0000;
                ring_patterns_reg[i]  <= 16'h0000;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_operation)
                            OP_SET_POSITION: begin
                                if (idx_ok) begin
                                    ring_positions_reg[widx] <= s_position;
                                    update_flags_reg[widx]   <= 1'b1;
                                end
                            end
                            OP_SET_GPC: begin
                                if (idx_ok) begin
                                    gpc_values_reg[widx] <= s_position;
                                end
                            end
                            OP_SET_METER: begin
                                if (idx_ok) begin
                                    meter_patterns_reg[widx] <= s_meter_bits;
                                end
                            end
                            OP_ADD_MASK: begin
                                update_flags_reg <= update_flags_reg
                                                    | s_update_mask[NUM_RINGS-1:0];
                            end
                            OP_UPDATE: begin
                                walk_reg  <= '0;
                                state_reg <= ST_WALK;
                            end
                            OP_SCAN: begin
                                if (ring_en_reg || meter_en_reg) begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    if (update_flags_reg[walk_reg]) begin
                        update_flags_reg[walk_reg]  <= 1'b0;
                        ring_patterns_reg[walk_reg] <= walk_pattern;
                    end
                    if (walk_reg == LAST_RING) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        walk_reg <= walk_reg + IDX_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (out_free) begin
                        scan_counter_reg <= scan_counter_next;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_SCAN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && out_free) begin
            rv_reg    <= both_groups || ring_en_reg;
            mv_reg    <= both_groups || !ring_en_reg;
            rmask_reg <= ring_half ? sel : 8'hff;
            mmask_reg <= ring_half ? 8'hff : sel;
            anode_reg <= anode_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_ring_cathode_valid  = rv_reg;
    assign m_ring_cathode_mask   = rmask_reg;
    assign m_meter_cathode_valid = mv_reg;
    assign m_meter_cathode_mask  = mmask_reg;
    assign m_anode_bits          = anode_reg;

    a_one_cathode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($countones(~{m_ring_cathode_mask, m_meter_cathode_mask}) == 1))
        else $error("scan word does not select exactly one cathode");

    a_absent_ring_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ring_cathode_valid) |-> (m_ring_cathode_mask == 8'hff))
        else $error("absent ring group driven");

    a_absent_meter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_meter_cathode_valid) |-> (m_meter_cathode_mask == 8'hff))
        else $error("absent meter group driven");

    a_update_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_UPDATE) |=>
        (state_reg == ST_WALK && walk_reg == '0))
        else $error("update word did not start the ring walk");

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && walk_reg == LAST_RING) |=>
        (state_reg == ST_IDLE && update_flags_reg[LAST_RING] == 1'b0))
        else $error("ring walk did not finish cleanly");

endmodule
